// File: rtl/core/mrqs_pkg.sv
// ----------------------------------------------------------------------------
// mrqs_pkg: shared types and constants for the multilevel ready-queue scheduler
// Level and process counts, command and status codes, and the classified item
// that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package mrqs_pkg;

  localparam int LEVELS    = 8;
  localparam int PROCS     = 64;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int HEAD_W    = $clog2(PROCS);
  localparam int CNT_W     = $clog2(PROCS + 1);
  localparam int ADDR_W    = $clog2(LEVELS * PROCS);
  localparam int MEM_DEPTH = LEVELS * PROCS;
  localparam int FIFO_DEPTH = 2;

  localparam logic [7:0] DEPTH_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_RESCHED = 2'd1,
    OP_START   = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_DEFER = 2'd2;

  typedef struct packed {
    op_t        op;
    logic [5:0] pid;
    logic [2:0] lvl;
    logic       elig;
  } item_t;

endpackage

// File: rtl/core/mrqs_front.sv
// ----------------------------------------------------------------------------
// mrqs_front: command intake
// Decodes each input transaction into a classified item and holds it in a
// two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module mrqs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic [5:0]         proc_id,
  input  logic [2:0]         prio_level,
  input  logic               still_eligible,
  output logic               item_valid,
  output mrqs_pkg::item_t    item,
  input  logic               take
);
  import mrqs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  item_t                   slots [FIFO_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [PTR_W:0]          cnt;
  logic                    wr_en;
  logic                    rd_en;
  item_t                   item_in;

  // classify the incoming command
  always_comb begin
    item_in.op   = op_t'(command);
    item_in.pid  = proc_id;
    item_in.lvl  = prio_level;
    item_in.elig = still_eligible;
  end

  assign full       = (cnt == (PTR_W+1)'(FIFO_DEPTH));
  assign item_valid = (cnt != '0);
  assign item       = slots[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = take && item_valid;

  // payload storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt <= cnt + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !rd_en |=> full)
    else $error("front queue lost an entry while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("front queue count out of range");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> !($past(rd_en)))
    else $error("back end took from an empty front queue");

endmodule

// File: rtl/core/mrqs_back.sv
// ----------------------------------------------------------------------------
// mrqs_back: scheduling engine
// Holds the per-level ring buffers, the running process and the deferral
// state; executes one item at a time and registers its result.
// ----------------------------------------------------------------------------
module mrqs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  mrqs_pkg::item_t    item,
  output logic               take,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic               switched,
  output logic [5:0]         next_pid,
  output logic [2:0]         next_level
);
  import mrqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t               state;
  logic [HEAD_W-1:0]    head  [LEVELS];
  logic [CNT_W-1:0]     count [LEVELS];
  logic [5:0]           running_pid;
  logic [7:0]           defer_depth;
  logic                 defer_pending;
  logic                 out_valid;

  // saved dispatch context
  logic [LVL_W-1:0]     d_top;
  logic [5:0]           d_old;
  logic                 d_push;
  logic [LVL_W-1:0]     d_plvl;

  // queue memory
  logic [5:0]           mem [MEM_DEPTH];
  logic [5:0]           rd_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [5:0]           mem_wd;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_ra;

  // decode helpers
  logic [LVL_W-1:0]     top;
  logic                 any;
  logic [LVL_W-1:0]     ilvl;
  logic                 lvl_ok;
  logic                 enq_ok;
  logic [HEAD_W-1:0]    enq_pos;
  logic                 disp_req;
  logic                 keep;
  logic [LVL_W-1:0]     plvl;
  logic [HEAD_W-1:0]    head_a;
  logic [CNT_W-1:0]     count_a;
  logic [HEAD_W-1:0]    d_pos;
  logic                 d_ok;
  logic [HEAD_W-1:0]    top_head_inc;

  function automatic logic [HEAD_W-1:0] wrap_add(logic [HEAD_W-1:0] h,
                                                 logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(PROCS)) begin
      s = s - (CNT_W+1)'(PROCS);
    end
    return HEAD_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] l,
                                                  logic [HEAD_W-1:0] p);
    return ADDR_W'(32'(l) * PROCS + 32'(p));
  endfunction

  assign take  = item_valid && (state == S_IDLE) && (!out_valid || pop);
  assign empty = !out_valid;

  // highest non-empty level
  always_comb begin
    top = '0;
    any = 1'b0;
    for (int k = 0; k < LEVELS; k++) begin
      if (count[k] != '0) begin
        top = LVL_W'(k);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    ilvl     = LVL_W'(item.lvl);
    lvl_ok   = (32'(item.lvl) < LEVELS);
    enq_ok   = (item.pid != 6'd0) && (32'(item.pid) < PROCS) && lvl_ok &&
               (count[ilvl] < CNT_W'(PROCS));
    enq_pos  = wrap_add(head[ilvl], count[ilvl]);
    disp_req = ((item.op == OP_RESCHED) && (defer_depth == 8'd0)) ||
               ((item.op == OP_STOP) && (defer_depth == 8'd1) && defer_pending);
    keep     = item.elig && (!any || (32'(item.lvl) > 32'(top)));
    plvl     = lvl_ok ? ilvl : LVL_W'(LEVELS - 1);
  end

  // re-queue position once the head of the top level has been removed
  always_comb begin
    top_head_inc = (head[d_top] == HEAD_W'(PROCS - 1)) ? '0 : head[d_top] + 1'b1;
    if (d_plvl == d_top) begin
      head_a  = top_head_inc;
      count_a = count[d_top] - 1'b1;
    end else begin
      head_a  = head[d_plvl];
      count_a = count[d_plvl];
    end
    d_pos = wrap_add(head_a, count_a);
    d_ok  = (count_a < CNT_W'(PROCS));
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_addr(ilvl, enq_pos);
    mem_wd = item.pid;
    mem_re = 1'b0;
    mem_ra = slot_addr(top, head[top]);
    if (take && (item.op == OP_ENQ) && enq_ok) begin
      mem_we = 1'b1;
    end
    if (take && disp_req && !keep && any) begin
      mem_re = 1'b1;
    end
    if ((state == S_DISP) && d_push && d_ok) begin
      mem_we = 1'b1;
      mem_wa = slot_addr(d_plvl, d_pos);
      mem_wd = d_old;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // result payload and dispatch context
  always_ff @(posedge clk) begin
    if (take) begin
      d_top  <= top;
      d_old  <= running_pid;
      d_push <= item.elig && (running_pid != 6'd0);
      d_plvl <= plvl;
      status     <= ST_OK;
      switched   <= 1'b0;
      next_level <= '0;
      unique case (item.op)
        OP_ENQ: begin
          if (!enq_ok) status <= ST_ERR;
        end
        OP_RESCHED: begin
          if (defer_depth != 8'd0) status <= ST_DEFER;
        end
        OP_START: begin
          if (defer_depth == DEPTH_MAX) status <= ST_ERR;
        end
        OP_STOP: begin
          if (defer_depth == 8'd0) status <= ST_ERR;
        end
        default: ;
      endcase
      if (disp_req && !keep && !any) begin
        switched <= 1'b1;
      end
    end else if (state == S_DISP) begin
      switched   <= 1'b1;
      next_level <= 3'(d_top);
      status     <= (d_push && !d_ok) ? ST_ERR : ST_OK;
    end
  end

  assign next_pid = running_pid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_pid   <= '0;
      defer_depth   <= '0;
      defer_pending <= 1'b0;
      out_valid     <= 1'b0;
      for (int k = 0; k < LEVELS; k++) begin
        head[k]  <= '0;
        count[k] <= '0;
      end
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            out_valid <= 1'b1;
            unique case (item.op)
              OP_ENQ: begin
                if (enq_ok) count[ilvl] <= count[ilvl] + 1'b1;
              end
              OP_RESCHED: begin
                if (defer_depth != 8'd0) defer_pending <= 1'b1;
              end
              OP_START: begin
                if (defer_depth != DEPTH_MAX) begin
                  if (defer_depth == 8'd0) defer_pending <= 1'b0;
                  defer_depth <= defer_depth + 1'b1;
                end
              end
              OP_STOP: begin
                if (defer_depth != 8'd0) begin
                  defer_depth <= defer_depth - 1'b1;
                  if (defer_depth == 8'd1) defer_pending <= 1'b0;
                end
              end
              default: ;
            endcase
            if (disp_req && !keep) begin
              if (any) begin
                out_valid <= 1'b0;
                state     <= S_DISP;
              end else begin
                running_pid <= '0;
              end
            end
          end
        end
        S_DISP: begin
          running_pid  <= rd_data;
          head[d_top]  <= top_head_inc;
          count[d_top] <= count[d_top] - 1'b1;
          if (d_push && d_ok) count[d_plvl] <= count_a + 1'b1;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_disp_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP) |-> !out_valid)
    else $error("dispatch in flight while a result is still held");
  a_disp_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP) |=> (state == S_IDLE) && out_valid)
    else $error("dispatch did not finish in one cycle");
  a_pending_depth: assert property (@(posedge clk) disable iff (rst)
    defer_pending |-> (defer_depth != 8'd0))
    else $error("deferred reschedule recorded with no deferral open");

endmodule

// File: rtl/core/multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler: priority run-queue scheduler
// One ring buffer per level in a shared memory; enqueue, reschedule and
// nested deferral commands, one result per command.
//
//   channel   dir  handshake        payload
//   command   in   push / full      command, proc_id, prio_level, still_eligible
//   result    out  pop / empty      status, switched, next_pid, next_level
//
// Enqueue, deferral and non-dispatching commands complete in the back end's idle
// state; a dispatch that pops a queue also visits S_DISP (memory read, then
// write-back). A two-entry intake queue and the result register decouple both
// sides. Reset is synchronous; all levels come up empty, idle process running,
// no clearing pass is needed. A stalled result holds; intake keeps filling.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command,
  input  logic [5:0] proc_id,
  input  logic [2:0] prio_level,
  input  logic       still_eligible,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic       switched,
  output logic [5:0] next_pid,
  output logic [2:0] next_level
);
  import mrqs_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;

  mrqs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .proc_id        (proc_id),
    .prio_level     (prio_level),
    .still_eligible (still_eligible),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take)
  );

  mrqs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .switched   (switched),
    .next_pid   (next_pid),
    .next_level (next_level)
  );

endmodule
